>>> sv/skrfi_pkg.sv
// skrfi_pkg: shared types and constants of the spectral kurtosis rfi mask detector
// register indexes of the csr port, field widths and the per-stage flag bundle
// no dependencies
`default_nettype none

package skrfi_pkg;

   // fixed field widths
   localparam int SK_W           = 16;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int COEF_FRAC_BITS = 24;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] REG_UPPER_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOWER_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BAND_START      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BAND_END        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_COUNT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TWO_POLS        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_AVERAGE_COEF    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MODE            = 3'd7;

   // mode bit positions
   localparam int MODE_NO_CHAN_TEST   = 0;
   localparam int MODE_NO_SAMPLE_TEST = 1;

   // reset values that are not zero
   localparam logic [12:0] CHANNEL_COUNT_RESET = 13'd4096;

   // flags carried down the pipeline with each beat
   typedef struct packed {
      logic chan_zap;
      logic sample_end;
      logic chk_a;
      logic chk_b;
   } flags_type;

endpackage

`default_nettype wire

>>> sv/sk_rfi_mask_detector_top.sv
// sk_rfi_mask_detector_top: each request beat is registered through every stage below before
// its response beat is presented; throughput one beat per cycle while the receiver keeps up.
// five register stages (input, accumulate, deviation, square, response) each with its own
// valid bit, so a stalled response only holds up stages that are full.
// reset (synchronous, active high) clears all valid bits, the channel index, sums and count,
// and loads the csr defaults (channel_count 4096, two_pols 1, all others 0).
// depends on skrfi_pkg
`default_nettype none

module sk_rfi_mask_detector_top
   import skrfi_pkg::*;
#(
   parameter int MAX_CHANNELS = 4096,
   parameter int SK_FRAC_BITS = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [SK_W-1:0]       req_sk_pol_a,
   input  wire logic [SK_W-1:0]       req_sk_pol_b,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_channel_zap,
   output logic                       rsp_sample_zap,
   output logic                       rsp_sample_end,
   // csr write port
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // derived widths
   localparam int IDX_W = $clog2(MAX_CHANNELS);          // channel index
   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);      // counts up to MAX_CHANNELS
   localparam int SUM_W = SK_W + IDX_W;                  // sum of up to MAX_CHANNELS estimates
   localparam int ONE_W = CNT_W + SK_FRAC_BITS;          // count scaled to unity
   localparam int DEV_W = (SUM_W > ONE_W) ? SUM_W : ONE_W;
   localparam int SQ_W  = 2 * DEV_W;
   localparam int RHS_W = CSR_DATA_W + CNT_W;
   // alignment of average_coef * count to the fraction bits of the squared deviation
   localparam int SHIFT = 2 * SK_FRAC_BITS - COEF_FRAC_BITS;
   localparam int LSH   = (SHIFT >= 0) ? SHIFT : 0;
   localparam int RSH   = (SHIFT < 0) ? -SHIFT : 0;
   localparam int CMP_W = (SQ_W > RHS_W + LSH) ? SQ_W : RHS_W + LSH;
   localparam logic [31:0] MAX_CH_U = MAX_CHANNELS;

   // ------------------------------------------------------------------
   // csr registers
   // ------------------------------------------------------------------
   logic [15:0]           upper_ff;
   logic [15:0]           lower_ff;
   logic [11:0]           band_start_ff;
   logic [12:0]           band_end_ff;
   logic [12:0]           chan_count_ff;
   logic                  two_pols_ff;
   logic [CSR_DATA_W-1:0] coef_ff;
   logic [1:0]            mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff      <= '0;
         lower_ff      <= '0;
         band_start_ff <= '0;
         band_end_ff   <= '0;
         chan_count_ff <= CHANNEL_COUNT_RESET;
         two_pols_ff   <= 1'b1;
         coef_ff       <= '0;
         mode_ff       <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_UPPER_THRESHOLD: upper_ff      <= csr_wdata[15:0];
            REG_LOWER_THRESHOLD: lower_ff      <= csr_wdata[15:0];
            REG_BAND_START:      band_start_ff <= csr_wdata[11:0];
            REG_BAND_END:        band_end_ff   <= csr_wdata[12:0];
            REG_CHANNEL_COUNT:   chan_count_ff <= csr_wdata[12:0];
            REG_TWO_POLS:        two_pols_ff   <= csr_wdata[0];
            REG_AVERAGE_COEF:    coef_ff       <= csr_wdata;
            REG_MODE:            mode_ff       <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // stage enables: a stage loads when it is empty or its successor loads
   // ------------------------------------------------------------------
   logic s0_v_ff, s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic out_en, s3_en, s2_en, s1_en, s0_en;

   assign out_en    = !out_v_ff || rsp_ready;
   assign s3_en     = !s3_v_ff || out_en;
   assign s2_en     = !s2_v_ff || s3_en;
   assign s1_en     = !s1_v_ff || s2_en;
   assign s0_en     = !s0_v_ff || s1_en;
   assign req_ready = s0_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s0_en)  s0_v_ff  <= req_valid;
         if (s1_en)  s1_v_ff  <= s0_v_ff;
         if (s2_en)  s2_v_ff  <= s1_v_ff;
         if (s3_en)  s3_v_ff  <= s2_v_ff;
         if (out_en) out_v_ff <= s3_v_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 0: input register
   // ------------------------------------------------------------------
   logic [SK_W-1:0] sk_a_ff, sk_b_ff;

   always_ff @(posedge clock) begin
      if (s0_en && req_valid) begin
         sk_a_ff <= req_sk_pol_a;
         sk_b_ff <= req_sk_pol_b;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: per-channel limits, band accumulation, end of sample
   // ------------------------------------------------------------------
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [SUM_W-1:0] sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;
   logic [CNT_W-1:0] good_ff, good_in;

   logic [CNT_W-1:0] eff_cnt;
   logic [31:0]      band_end_eff;
   logic [31:0]      idx_wide;
   logic             in_band, zap, good, last;
   logic [SUM_W-1:0] sum_a_acc, sum_b_acc;
   logic [CNT_W-1:0] good_acc;
   flags_type        s1_flags_in;
   logic             s1_step;

   function automatic logic out_of_limits(input logic [SK_W-1:0] v,
                                          input logic [15:0] hi,
                                          input logic [15:0] lo);
      return (v > hi) || (v < lo);
   endfunction

   always_comb begin
      // zero or an oversized count means the full channel set
      if (chan_count_ff == '0 || 32'(chan_count_ff) > MAX_CH_U) begin
         eff_cnt = CNT_W'(MAX_CH_U);
      end else begin
         eff_cnt = CNT_W'(chan_count_ff);
      end
      band_end_eff = (band_end_ff == '0) ? 32'(eff_cnt) : 32'(band_end_ff);
      idx_wide     = 32'(idx_ff);
      in_band      = (idx_wide >= 32'(band_start_ff)) && (idx_wide < band_end_eff);

      zap = !mode_ff[MODE_NO_CHAN_TEST] &&
            (out_of_limits(sk_a_ff, upper_ff, lower_ff) ||
             (two_pols_ff && out_of_limits(sk_b_ff, upper_ff, lower_ff)));
      good = !zap && in_band;

      sum_a_acc = sum_a_ff + (good ? SUM_W'(sk_a_ff) : '0);
      sum_b_acc = sum_b_ff + (good ? SUM_W'(sk_b_ff) : '0);
      good_acc  = good_ff + CNT_W'(good);

      // also catches a count lowered below the running index
      last = (idx_wide + 32'd1) >= 32'(eff_cnt);

      s1_flags_in.chan_zap   = zap;
      s1_flags_in.sample_end = last;
      s1_flags_in.chk_a      = last && !mode_ff[MODE_NO_SAMPLE_TEST] && (good_acc != '0);
      s1_flags_in.chk_b      = s1_flags_in.chk_a && two_pols_ff;

      s1_step = s0_v_ff && s1_en;
      idx_in   = idx_ff;
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      good_in  = good_ff;
      if (s1_step) begin
         if (last) begin
            idx_in   = '0;
            sum_a_in = '0;
            sum_b_in = '0;
            good_in  = '0;
         end else begin
            idx_in   = idx_ff + IDX_W'(1);
            sum_a_in = sum_a_acc;
            sum_b_in = sum_b_acc;
            good_in  = good_acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         sum_a_ff <= '0;
         sum_b_ff <= '0;
         good_ff  <= '0;
      end else begin
         idx_ff   <= idx_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         good_ff  <= good_in;
      end
   end

   // final sums of the sample travel with the last beat
   flags_type        s1_flags_ff;
   logic [SUM_W-1:0] s1_sum_a_ff, s1_sum_b_ff;
   logic [CNT_W-1:0] s1_cnt_ff;

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_flags_ff <= s1_flags_in;
         s1_sum_a_ff <= sum_a_acc;
         s1_sum_b_ff <= sum_b_acc;
         s1_cnt_ff   <= good_acc;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: deviation from unity mean and coef * count
   // ------------------------------------------------------------------
   logic [DEV_W-1:0] one_d, sum_ad, sum_bd, dev_a_in, dev_b_in;
   logic [RHS_W-1:0] rhs_in;

   always_comb begin
      one_d    = DEV_W'(s1_cnt_ff) << SK_FRAC_BITS;
      sum_ad   = DEV_W'(s1_sum_a_ff);
      sum_bd   = DEV_W'(s1_sum_b_ff);
      dev_a_in = (sum_ad >= one_d) ? (sum_ad - one_d) : (one_d - sum_ad);
      dev_b_in = (sum_bd >= one_d) ? (sum_bd - one_d) : (one_d - sum_bd);
      rhs_in   = RHS_W'(coef_ff) * RHS_W'(s1_cnt_ff);
   end

   flags_type        s2_flags_ff;
   logic [DEV_W-1:0] dev_a_ff, dev_b_ff;
   logic [RHS_W-1:0] rhs_ff;

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_flags_ff <= s1_flags_ff;
         dev_a_ff    <= dev_a_in;
         dev_b_ff    <= dev_b_in;
         rhs_ff      <= rhs_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: squared deviations, limit aligned to their fraction bits
   // ------------------------------------------------------------------
   logic [SQ_W-1:0]  sq_a_in, sq_b_in;
   logic [CMP_W-1:0] lim_in;

   always_comb begin
      sq_a_in = SQ_W'(dev_a_ff) * SQ_W'(dev_a_ff);
      sq_b_in = SQ_W'(dev_b_ff) * SQ_W'(dev_b_ff);
      lim_in  = (CMP_W'(rhs_ff) << LSH) >> RSH;
   end

   flags_type        s3_flags_ff;
   logic [SQ_W-1:0]  sq_a_ff, sq_b_ff;
   logic [CMP_W-1:0] lim_ff;

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_flags_ff <= s2_flags_ff;
         sq_a_ff     <= sq_a_in;
         sq_b_ff     <= sq_b_in;
         lim_ff      <= lim_in;
      end
   end

   // ------------------------------------------------------------------
   // response register: compare and present the beat
   // ------------------------------------------------------------------
   logic szap_in;

   assign szap_in = (s3_flags_ff.chk_a && (CMP_W'(sq_a_ff) > lim_ff)) ||
                    (s3_flags_ff.chk_b && (CMP_W'(sq_b_ff) > lim_ff));

   logic chan_zap_ff, sample_zap_ff, sample_end_ff;

   always_ff @(posedge clock) begin
      if (out_en) begin
         chan_zap_ff   <= s3_flags_ff.chan_zap;
         sample_zap_ff <= szap_in;
         sample_end_ff <= s3_flags_ff.sample_end;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_channel_zap = chan_zap_ff;
   assign rsp_sample_zap  = sample_zap_ff;
   assign rsp_sample_end  = sample_end_ff;

endmodule

`default_nettype wire

>>> tb/sk_rfi_mask_detector_top_tb.sv
// sk_rfi_mask_detector_top_tb: self-checking bench for the sk rfi mask detector top level
// drives sk beats and csr writes, predicts the zap flags of every beat and scores responses
// depends on skrfi_pkg and sk_rfi_mask_detector_top

module sk_rfi_mask_detector_top_tb;
   import skrfi_pkg::*;

   localparam int MAX_CHANNELS  = 4096;
   localparam int SK_FRAC_BITS  = 12;
   localparam int PIPE_LATENCY  = 4;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PHASES = 12;
   localparam int REPORT_LIMIT  = 10;
   localparam int DIRECTED_ROWS = 42;
   localparam int SK_UNITY      = 1 << SK_FRAC_BITS;

   // flags of one response beat
   typedef struct packed {
      logic channel_zap;
      logic sample_zap;
      logic sample_end;
   } zap_flags_type;

   // directed table: csr write, beat scored by the predictor, or beat with a hand-written answer
   typedef enum logic [1:0] {ROW_WRITE, ROW_PREDICT, ROW_TYPED} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] value;
      logic [SK_W-1:0]       pol_a;
      logic [SK_W-1:0]       pol_b;
      zap_flags_type         flags;
   } stim_row_type;

   // dut ports, all inputs known from time zero
   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic [SK_W-1:0]       req_sk_pol_a  = '0;
   logic [SK_W-1:0]       req_sk_pol_b  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic                  rsp_channel_zap;
   logic                  rsp_sample_zap;
   logic                  rsp_sample_end;
   logic                  csr_we        = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index     = '0;
   logic [CSR_DATA_W-1:0] csr_wdata     = '0;

   // idle percentages of the two sides, changed per segment
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   // scoreboard
   zap_flags_type expected_zaps [$];
   int            fault_count = 0;
   int            beat_count  = 0;

   // predictor copy of the csr bank
   logic [15:0] upper_limit;
   logic [15:0] lower_limit;
   logic [11:0] band_first;
   logic [12:0] band_stop;
   logic [12:0] chans_per_sample;
   logic        dual_pol;
   logic [31:0] dev_coef;
   logic [1:0]  test_mode;

   // predictor copy of the running sample state
   int unsigned     chan_pos;
   longint unsigned sum_a;
   longint unsigned sum_b;
   int unsigned     kept_chans;

   // hand-checked opening sequence; register names are placeholders on beat rows
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // straight after reset both limits are zero, so only zero passes
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'h0000, 16'h0000, 3'b000},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'hffff, 16'h0000, 3'b100},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'h0000, 16'hffff, 3'b100},
      '{ROW_WRITE,   REG_UPPER_THRESHOLD, 32'h0000_ffff, 16'h0000, 16'h0000, 3'b000},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'hffff, 16'hffff, 3'b000},
      // count lowered below the running index: next beat closes the sample
      '{ROW_WRITE,   REG_CHANNEL_COUNT,   32'd3,         16'h0000, 16'h0000, 3'b000},
      '{ROW_PREDICT, REG_MODE,            32'h0,         16'h1000, 16'h1000, 3'b000},
      // widest coefficient
      '{ROW_WRITE,   REG_AVERAGE_COEF,    32'hffff_ffff, 16'h0000, 16'h0000, 3'b000},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'h1000, 16'h1000, 3'b000},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'h1000, 16'h1000, 3'b000},
      '{ROW_PREDICT, REG_MODE,            32'h0,         16'h2000, 16'h0800, 3'b000},
      // zero coefficient: any deviation of the mean trips the sample test
      '{ROW_WRITE,   REG_AVERAGE_COEF,    32'h0,         16'h0000, 16'h0000, 3'b000},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'h1001, 16'h1000, 3'b000},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'h1001, 16'h1000, 3'b000},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'h1001, 16'h1000, 3'b011},
      // single pol, limits pinched to exactly unity, pol b must be ignored
      '{ROW_WRITE,   REG_TWO_POLS,        32'h0,         16'h0000, 16'h0000, 3'b000},
      '{ROW_WRITE,   REG_LOWER_THRESHOLD, 32'h0000_1000, 16'h0000, 16'h0000, 3'b000},
      '{ROW_WRITE,   REG_UPPER_THRESHOLD, 32'h0000_1000, 16'h0000, 16'h0000, 3'b000},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'h1000, 16'h0000, 3'b000},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'h1000, 16'hffff, 3'b000},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'h1000, 16'h0000, 3'b001},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'h0fff, 16'h1000, 3'b100},
      // per-channel test off: everything in band is summed
      '{ROW_WRITE,   REG_MODE,            32'd1,         16'h0000, 16'h0000, 3'b000},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'h0000, 16'h0000, 3'b000},
      '{ROW_PREDICT, REG_MODE,            32'h0,         16'hffff, 16'h0000, 3'b000},
      // sample test off
      '{ROW_WRITE,   REG_MODE,            32'd2,         16'h0000, 16'h0000, 3'b000},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'hffff, 16'h0000, 3'b100},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'hffff, 16'h0000, 3'b100},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'h0000, 16'h0000, 3'b101},
      // both tests off
      '{ROW_WRITE,   REG_MODE,            32'd3,         16'h0000, 16'h0000, 3'b000},
      '{ROW_WRITE,   REG_TWO_POLS,        32'd1,         16'h0000, 16'h0000, 3'b000},
      '{ROW_WRITE,   REG_BAND_START,      32'd1,         16'h0000, 16'h0000, 3'b000},
      '{ROW_WRITE,   REG_BAND_END,        32'd2,         16'h0000, 16'h0000, 3'b000},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'h0000, 16'hffff, 3'b000},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'hffff, 16'h0000, 3'b000},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'h1234, 16'habcd, 3'b001},
      // band lies past the channel count: nothing kept, sample test stays quiet
      '{ROW_WRITE,   REG_MODE,            32'd0,         16'h0000, 16'h0000, 3'b000},
      '{ROW_WRITE,   REG_BAND_START,      32'h0000_0fff, 16'h0000, 16'h0000, 3'b000},
      '{ROW_WRITE,   REG_BAND_END,        32'h0000_1000, 16'h0000, 16'h0000, 3'b000},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'h1000, 16'h1000, 3'b000},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'h1000, 16'h1000, 3'b000},
      '{ROW_TYPED,   REG_MODE,            32'h0,         16'h1000, 16'h1000, 3'b001}
   };

   sk_rfi_mask_detector_top #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .SK_FRAC_BITS (SK_FRAC_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sk_pol_a    (req_sk_pol_a),
      .req_sk_pol_b    (req_sk_pol_b),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_channel_zap (rsp_channel_zap),
      .rsp_sample_zap  (rsp_sample_zap),
      .rsp_sample_end  (rsp_sample_end),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 8 unit period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // per-channel limit test, limits are inclusive
   function automatic logic outside_limits(input logic [15:0] sk);
      return (sk > upper_limit) || (sk < lower_limit);
   endfunction

   // squared deviation of the sum from n times unity against coef times n, no division
   function automatic logic mean_off_unity(input longint unsigned total, input int unsigned n);
      longint unsigned unity;
      longint unsigned dev;
      longint unsigned dev_sq;
      longint unsigned bound;
      int              shift;
      unity  = n;
      unity  = unity << SK_FRAC_BITS;
      dev    = (total >= unity) ? total - unity : unity - total;
      dev_sq = dev * dev;
      bound  = dev_coef;
      bound  = bound * n;
      // line the 2*frac bits of the square up with the coefficient's fraction bits
      shift  = 2 * SK_FRAC_BITS - COEF_FRAC_BITS;
      if (shift >= 0) begin
         return dev_sq > (bound << shift);
      end
      return dev_sq > (bound >> (-shift));
   endfunction

   // expected flags of one beat; advances the predictor's sample state
   function automatic zap_flags_type predict_zaps(input logic [15:0] a, input logic [15:0] b);
      int unsigned   count_eff;
      int unsigned   stop;
      zap_flags_type f;
      count_eff = chans_per_sample;
      // zero or anything past the maximum behaves as the maximum
      if (count_eff == 0 || count_eff > MAX_CHANNELS) begin
         count_eff = MAX_CHANNELS;
      end
      stop = (band_stop == 0) ? count_eff : band_stop;
      f = '0;
      if (!test_mode[MODE_NO_CHAN_TEST]) begin
         f.channel_zap = outside_limits(a) || (dual_pol && outside_limits(b));
      end
      if (!f.channel_zap && chan_pos >= band_first && chan_pos < stop) begin
         sum_a      += a;
         sum_b      += b;
         kept_chans += 1;
      end
      // index at or past the last channel closes the sample, even after a lowered count
      f.sample_end = (chan_pos + 1 >= count_eff);
      if (f.sample_end) begin
         if (!test_mode[MODE_NO_SAMPLE_TEST] && kept_chans > 0) begin
            f.sample_zap = mean_off_unity(sum_a, kept_chans) ||
                           (dual_pol && mean_off_unity(sum_b, kept_chans));
         end
         chan_pos   = 0;
         sum_a      = 0;
         sum_b      = 0;
         kept_chans = 0;
      end else begin
         chan_pos += 1;
      end
      return f;
   endfunction

   // sk value: mostly near unity, some at or just past the current limits, some anywhere
   function automatic logic [15:0] pick_sk(input int spread);
      int v;
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4: v = $urandom_range(0, 65535);
         5, 6: begin
            case ($urandom_range(0, 3))
               0:       v = int'(lower_limit) - 1;
               1:       v = int'(lower_limit);
               2:       v = int'(upper_limit);
               default: v = int'(upper_limit) + 1;
            endcase
         end
         default: v = SK_UNITY + int'($urandom_range(0, 2 * spread)) - spread;
      endcase
      if (v < 0) begin
         v = 0;
      end
      if (v > 65535) begin
         v = 65535;
      end
      return v[15:0];
   endfunction

   // one csr write; sometimes junk above the field to check the masking
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      logic [31:0] field_mask;
      logic [31:0] field;
      case (idx)
         REG_UPPER_THRESHOLD, REG_LOWER_THRESHOLD: field_mask = 32'h0000_ffff;
         REG_BAND_START:                           field_mask = 32'h0000_0fff;
         REG_BAND_END, REG_CHANNEL_COUNT:          field_mask = 32'h0000_1fff;
         REG_TWO_POLS:                             field_mask = 32'h0000_0001;
         REG_AVERAGE_COEF:                         field_mask = 32'hffff_ffff;
         default:                                  field_mask = 32'h0000_0003;
      endcase
      if ($urandom_range(0, 3) == 0) begin
         value = value | ($urandom() & ~field_mask);
      end
      field = value & field_mask;
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_UPPER_THRESHOLD: upper_limit      = field[15:0];
         REG_LOWER_THRESHOLD: lower_limit      = field[15:0];
         REG_BAND_START:      band_first       = field[11:0];
         REG_BAND_END:        band_stop        = field[12:0];
         REG_CHANNEL_COUNT:   chans_per_sample = field[12:0];
         REG_TWO_POLS:        dual_pol         = field[0];
         REG_AVERAGE_COEF:    dev_coef         = field;
         default:             test_mode        = field[1:0];
      endcase
      // write enable drops between writes so back-to-back writes never share a step
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // sender holds off until every outstanding response beat is back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_zaps.size() != 0) begin
         @(posedge clock);
      end
      repeat (2) @(posedge clock);
   endtask

   // one request beat; valid stays up between back-to-back beats
   task automatic send_beat(input logic [15:0] a, input logic [15:0] b,
                            input logic use_given, input zap_flags_type given);
      zap_flags_type predicted;
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_valid    <= 1'b1;
      req_sk_pol_a <= a;
      req_sk_pol_b <= b;
      do begin
         @(posedge clock);
      end while (!req_ready);
      // accepted at this edge
      predicted = predict_zaps(a, b);
      expected_zaps.push_back(use_given ? given : predicted);
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // response scoring against the oldest expectation
   always @(posedge clock) begin : response_check
      zap_flags_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_zaps.size() == 0) begin
            if (fault_count < REPORT_LIMIT) begin
               $display("unexpected response beat: channel_zap %b sample_zap %b sample_end %b",
                        rsp_channel_zap, rsp_sample_zap, rsp_sample_end);
            end
            fault_count++;
         end else begin
            want = expected_zaps.pop_front();
            if (rsp_channel_zap !== want.channel_zap || rsp_sample_zap !== want.sample_zap ||
                rsp_sample_end !== want.sample_end) begin
               if (fault_count < REPORT_LIMIT) begin
                  $display("beat %0d: chan/sample zap, end exp %b%b%b got %b%b%b",
                           beat_count, want.channel_zap, want.sample_zap, want.sample_end,
                           rsp_channel_zap, rsp_sample_zap, rsp_sample_end);
               end
               fault_count++;
            end
            beat_count++;
         end
      end
   end

   // hard stop if the flow ever hangs
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sk_rfi_mask_detector_top_tb: done, errors");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int beats;
      int spread;
      int chans;
      int eff;
      int lo;
      int hi;
      logic [31:0] coef_pick;
      logic [31:0] band_lo_pick;
      logic [31:0] band_hi_pick;
      logic [31:0] mode_pick;

      // predictor starts from the reset values of the csr bank and the sample state
      upper_limit      = '0;
      lower_limit      = '0;
      band_first       = '0;
      band_stop        = '0;
      chans_per_sample = CHANNEL_COUNT_RESET;
      dual_pol         = 1'b1;
      dev_coef         = '0;
      test_mode        = '0;
      chan_pos         = 0;
      sum_a            = 0;
      sum_b            = 0;
      kept_chans       = 0;

      // first segment: sender idles a little, receiver a lot
      req_idle_pct = 15;
      rsp_idle_pct = 58;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table, writes only once the pipe is empty
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WRITE) begin
            drain_results();
            write_reg(directed_rows[r].index, directed_rows[r].value);
         end else begin
            send_beat(directed_rows[r].pol_a, directed_rows[r].pol_b,
                      directed_rows[r].kind == ROW_TYPED, directed_rows[r].flags);
         end
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         // three idle segments: sender light, then receiver light, then no idling
         case (phase * 3 / RANDOM_PHASES)
            0: begin
               req_idle_pct = 15;
               rsp_idle_pct = 58;
            end
            1: begin
               req_idle_pct = 58;
               rsp_idle_pct = 15;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase

         // channel count: mostly short samples, a few zero, at or beyond the maximum
         case ($urandom_range(0, 9))
            0:       chans = 0;
            1:       chans = MAX_CHANNELS;
            2:       chans = $urandom_range(MAX_CHANNELS + 1, 8191);
            3, 4:    chans = $urandom_range(17, 64);
            default: chans = $urandom_range(1, 16);
         endcase
         eff = (chans == 0 || chans > MAX_CHANNELS) ? MAX_CHANNELS : chans;

         case ($urandom_range(0, 5))
            0:       band_lo_pick = 0;
            1:       band_lo_pick = $urandom_range(0, 4095);
            default: band_lo_pick = $urandom_range(0, eff - 1);
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2: band_hi_pick = 0;
            3:       band_hi_pick = MAX_CHANNELS;
            default: band_hi_pick = $urandom_range(0, eff + 2);
         endcase

         spread = $urandom_range(16, 2048);
         case ($urandom_range(0, 9))
            0: begin
               lo = 0;
               hi = 65535;
            end
            1: begin
               // may come out inverted, zapping every channel
               lo = $urandom_range(0, 65535);
               hi = $urandom_range(0, 65535);
            end
            default: begin
               lo = SK_UNITY - int'($urandom_range(0, 3000));
               hi = SK_UNITY + int'($urandom_range(0, 12000));
            end
         endcase

         // coefficient mostly near where the sample test flips for this spread, else zero, the maximum or any value
         case ($urandom_range(0, 7))
            0:       coef_pick = 32'h0;
            1:       coef_pick = 32'hffff_ffff;
            2:       coef_pick = $urandom();
            default: coef_pick = $urandom_range(0, spread * spread);
         endcase
         case ($urandom_range(0, 7))
            0:       mode_pick = 1;
            1:       mode_pick = 2;
            2:       mode_pick = 3;
            default: mode_pick = 0;
         endcase

         drain_results();
         write_reg(REG_UPPER_THRESHOLD, hi);
         write_reg(REG_LOWER_THRESHOLD, lo);
         write_reg(REG_BAND_START, band_lo_pick);
         write_reg(REG_BAND_END, band_hi_pick);
         write_reg(REG_CHANNEL_COUNT, chans);
         write_reg(REG_TWO_POLS, $urandom_range(0, 1));
         write_reg(REG_AVERAGE_COEF, coef_pick);
         write_reg(REG_MODE, mode_pick);

         beats = $urandom_range(55, 85);
         repeat (beats) begin
            // now and then the sender waits for the pipe to empty mid-phase
            if ($urandom_range(0, 49) == 0) begin
               drain_results();
            end
            send_beat(pick_sk(spread), pick_sk(spread), 1'b0, '0);
         end
      end

      // let the last beats come back, then wait on for strays
      drain_results();
      repeat (PIPE_LATENCY * 4) @(posedge clock);
      if (fault_count == 0) begin
         $display("sk_rfi_mask_detector_top_tb: done, clean");
      end else begin
         $display("sk_rfi_mask_detector_top_tb: done, errors");
      end
      $finish;
   end

endmodule

>>> sk_rfi_mask_detector_top.f
sv/skrfi_pkg.sv
sv/sk_rfi_mask_detector_top.sv
tb/sk_rfi_mask_detector_top_tb.sv
